>>> hdl/hierarchical_pivot_transform_macros.svh
// Assertion macros shared by the checker of the pivot transform block.
`ifndef HIERARCHICAL_PIVOT_TRANSFORM_MACROS_SVH
`define HIERARCHICAL_PIVOT_TRANSFORM_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define HPT_ASSERT_IMPLY(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("%m: implication failed");

// Next-cycle implication, never disabled.
`define HPT_ASSERT_NEXT(label, clk, a, b) \
   label: assert property (@(posedge clk) (a) |=> (b)) \
      else $error("%m: next-cycle implication failed");

`endif

>>> hdl/hpt_pkg.sv
// Package: widths, constants, payload types and helpers of the pivot transform.
package hpt_pkg;

   localparam int POS_W    = 32;
   localparam int ANGLE_W  = 24;
   localparam int FRAC_W   = 16;
   localparam int SIZE_W   = 16;
   localparam int ZOOM_W   = 16;
   localparam logic [ZOOM_W-1:0] ZOOM_RESET = 16'd256;

   localparam int TRIG_BITS_DEFAULT = 16;
   localparam int TRIG_MAX  = 24;

   localparam int FS_W     = FRAC_W + SIZE_W + 1;   // frac * size
   localparam int VEC_W    = FS_W + ZOOM_W + 1;     // frac * size * zoom, Q.22
   localparam int TRIG_W   = 18;                    // Q1.14 with headroom
   localparam int PROD_W   = VEC_W + TRIG_W;
   localparam int SUM_W    = PROD_W + 1;
   localparam int RES_SHIFT = 28;
   localparam int RES_W    = SUM_W - RES_SHIFT;     // rotated vector, Q.8
   localparam int CORDIC_W = 33;                    // Q2.30 with headroom
   localparam int PHASE_W  = 26;                    // Q.16 degrees

   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 33'sd652032874;

   typedef struct packed {
      logic signed [POS_W-1:0]   px;
      logic signed [POS_W-1:0]   py;
      logic signed [ANGLE_W-1:0] wa;
   } scal_type;

   typedef struct packed {
      logic signed [VEC_W-1:0] pvx;
      logic signed [VEC_W-1:0] pvy;
      logic signed [VEC_W-1:0] ofx;
      logic signed [VEC_W-1:0] ofy;
   } vec_type;

   typedef struct packed {
      vec_type  vec;
      scal_type scal;
   } stage_type;

   function automatic logic signed [PHASE_W-1:0] hpt_atan(input int i);
      logic signed [PHASE_W-1:0] v;
      case (i)
         0:  v = 26'sd2949120;
         1:  v = 26'sd1740967;
         2:  v = 26'sd919879;
         3:  v = 26'sd466945;
         4:  v = 26'sd234379;
         5:  v = 26'sd117304;
         6:  v = 26'sd58666;
         7:  v = 26'sd29335;
         8:  v = 26'sd14668;
         9:  v = 26'sd7334;
         10: v = 26'sd3667;
         11: v = 26'sd1833;
         12: v = 26'sd917;
         13: v = 26'sd458;
         14: v = 26'sd229;
         15: v = 26'sd115;
         16: v = 26'sd57;
         17: v = 26'sd29;
         18: v = 26'sd14;
         19: v = 26'sd7;
         20: v = 26'sd4;
         21: v = 26'sd2;
         22: v = 26'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction

   // Position plus rotated vector, clamped to the signed position range.
   // The sum fits POS_W bits when every bit above the position sign matches it.
   function automatic logic signed [POS_W-1:0] hpt_sat_add(
      input logic signed [POS_W-1:0] p, input logic signed [RES_W-1:0] r);
      logic signed [RES_W:0] s;
      s = (RES_W+1)'(p) + (RES_W+1)'(r);
      if (!s[RES_W] && (|s[RES_W-1:POS_W-1]))
         return {1'b0, {(POS_W-1){1'b1}}};
      else if (s[RES_W] && !(&s[RES_W-1:POS_W-1]))
         return {1'b1, {(POS_W-1){1'b0}}};
      else
         return s[POS_W-1:0];
   endfunction

endpackage

>>> hdl/hpt_delay.sv
// Delay line for a payload word with a reset-cleared valid bit.
module hpt_delay #(
   parameter int DEPTH = 2,
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   output logic [WIDTH-1:0] out_data
);
   logic [DEPTH-1:0] valid_ff;
   logic [DEPTH-1:0] valid_in;
   logic [WIDTH-1:0] data_ff [DEPTH];

   always_comb begin
      valid_in = {valid_ff[DEPTH-2:0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff[0] <= in_data;
      for (int i = 1; i < DEPTH; i++) begin
         data_ff[i] <= data_ff[i-1];
      end
   end

   assign out_valid = valid_ff[DEPTH-1];
   assign out_data  = data_ff[DEPTH-1];
endmodule

>>> hdl/hpt_sincos.sv
// Pipelined angle reduction and CORDIC giving Q1.14 sine and cosine.
module hpt_sincos #(
   parameter int TRIG_BITS = hpt_pkg::TRIG_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic signed [hpt_pkg::ANGLE_W-1:0]  angle,
   output logic signed [hpt_pkg::TRIG_W-1:0]   sin_q14,
   output logic signed [hpt_pkg::TRIG_W-1:0]   cos_q14
);
   import hpt_pkg::*;

   localparam int N = (TRIG_BITS > TRIG_MAX) ? TRIG_MAX : TRIG_BITS;
   localparam int HI_W = ANGLE_W - 11;
   localparam logic [14:0] RECIP45 = 15'd23302;  // 2^20 / 45, rounded up
   localparam logic [16:0] TURN    = 17'd92160;  // 360 degrees, Q.8
   localparam logic [16:0] BIAS    = 17'd2048;   // 2^23 mod 92160
   localparam logic signed [17:0] HALF_TURN = 18'sd46080;
   localparam logic signed [17:0] QUARTER   = 18'sd23040;

   // Stage A: quotient of the biased angle's upper bits by 45
   logic [HI_W-1:0] hi_ff, hi_in;
   logic [10:0]     lo_ff, lo_in;
   logic [7:0]      q_ff, q_in;
   logic [ANGLE_W-1:0] biased;
   logic [HI_W+14:0]   qprod;

   always_comb begin
      biased = {~angle[ANGLE_W-1], angle[ANGLE_W-2:0]};
      hi_in  = biased[ANGLE_W-1:11];
      lo_in  = biased[10:0];
      qprod  = hi_in * RECIP45;
      q_in   = qprod[HI_W+14:20];
   end

   always_ff @(posedge clock) begin
      hi_ff <= hi_in;
      lo_ff <= lo_in;
      q_ff  <= q_in;
   end

   // CORDIC stage registers; entry 0 is loaded by stage B
   logic signed [CORDIC_W-1:0] x_ff [N+1];
   logic signed [CORDIC_W-1:0] y_ff [N+1];
   logic signed [PHASE_W-1:0]  d_ff [N+1];
   logic                       neg_ff [N+1];

   // Stage B: remainder, remove bias, fold into [-90, 90]
   logic signed [PHASE_W-1:0] d0_in;
   logic neg0_in;
   logic [13:0] q45;
   logic [13:0] rem;
   logic [16:0] rm, rr;
   logic signed [17:0] rs;

   always_comb begin
      q45 = q_ff * 6'd45;
      rem = 14'(hi_ff) - q45;
      rm  = {rem[5:0], lo_ff};
      if (rm < BIAS)
         rr = rm + (TURN - BIAS);
      else
         rr = rm - BIAS;
      rs = $signed({1'b0, rr});
      if (rs > HALF_TURN)
         rs = rs - $signed({1'b0, TURN});
      neg0_in = 1'b0;
      if (rs > QUARTER) begin
         rs = rs - HALF_TURN;
         neg0_in = 1'b1;
      end else if (rs < -QUARTER) begin
         rs = rs + HALF_TURN;
         neg0_in = 1'b1;
      end
      d0_in = PHASE_W'(rs) <<< 8;
   end

   always_ff @(posedge clock) begin
      x_ff[0]   <= CORDIC_GAIN;
      y_ff[0]   <= '0;
      d_ff[0]   <= d0_in;
      neg_ff[0] <= neg0_in;
   end

   // CORDIC stages, one micro-rotation each
   for (genvar i = 0; i < N; i++) begin : g_iter
      logic signed [CORDIC_W-1:0] x_in, y_in;
      logic signed [PHASE_W-1:0]  d_in;
      always_comb begin
         if (d_ff[i] >= 0) begin
            x_in = x_ff[i] - (y_ff[i] >>> i);
            y_in = y_ff[i] + (x_ff[i] >>> i);
            d_in = d_ff[i] - hpt_atan(i);
         end else begin
            x_in = x_ff[i] + (y_ff[i] >>> i);
            y_in = y_ff[i] - (x_ff[i] >>> i);
            d_in = d_ff[i] + hpt_atan(i);
         end
      end
      always_ff @(posedge clock) begin
         x_ff[i+1]   <= x_in;
         y_ff[i+1]   <= y_in;
         d_ff[i+1]   <= d_in;
         neg_ff[i+1] <= neg_ff[i];
      end
   end

   // Round half up to Q1.14 and undo the quadrant fold
   logic signed [TRIG_W-1:0] sin_ff, sin_in, cos_ff, cos_in;
   logic signed [CORDIC_W-1:0] xr, yr;

   always_comb begin
      xr = x_ff[N] + CORDIC_W'(32768);
      yr = y_ff[N] + CORDIC_W'(32768);
      cos_in = TRIG_W'($signed(xr[CORDIC_W-1:16]));
      sin_in = TRIG_W'($signed(yr[CORDIC_W-1:16]));
      if (neg_ff[N]) begin
         cos_in = -cos_in;
         sin_in = -sin_in;
      end
   end

   always_ff @(posedge clock) begin
      sin_ff <= sin_in;
      cos_ff <= cos_in;
   end

   assign sin_q14 = sin_ff;
   assign cos_q14 = cos_ff;
endmodule

>>> hdl/hpt_rotate.sv
// Two-stage rotation of a Q.22 vector by Q1.14 sine and cosine, rounded to Q.8.
module hpt_rotate (
   input  logic                              clock,
   input  logic signed [hpt_pkg::VEC_W-1:0]  vx,
   input  logic signed [hpt_pkg::VEC_W-1:0]  vy,
   input  logic signed [hpt_pkg::TRIG_W-1:0] sin_q14,
   input  logic signed [hpt_pkg::TRIG_W-1:0] cos_q14,
   output logic signed [hpt_pkg::RES_W-1:0]  rx,
   output logic signed [hpt_pkg::RES_W-1:0]  ry
);
   import hpt_pkg::*;

   logic signed [PROD_W-1:0] xc_ff, xs_ff, yc_ff, ys_ff;
   logic signed [PROD_W-1:0] xc_in, xs_in, yc_in, ys_in;
   logic signed [RES_W-1:0]  rx_ff, ry_ff, rx_in, ry_in;
   logic signed [SUM_W-1:0]  sx, sy;

   always_comb begin
      xc_in = vx * cos_q14;
      xs_in = vx * sin_q14;
      yc_in = vy * cos_q14;
      ys_in = vy * sin_q14;
   end

   always_ff @(posedge clock) begin
      xc_ff <= xc_in;
      xs_ff <= xs_in;
      yc_ff <= yc_in;
      ys_ff <= ys_in;
   end

   always_comb begin
      sx = SUM_W'(xc_ff) - SUM_W'(ys_ff) + (SUM_W'(1) <<< (RES_SHIFT - 1));
      sy = SUM_W'(xs_ff) + SUM_W'(yc_ff) + (SUM_W'(1) <<< (RES_SHIFT - 1));
      rx_in = sx[SUM_W-1:RES_SHIFT];
      ry_in = sy[SUM_W-1:RES_SHIFT];
   end

   always_ff @(posedge clock) begin
      rx_ff <= rx_in;
      ry_ff <= ry_in;
   end

   assign rx = rx_ff;
   assign ry = ry_ff;
endmodule

>>> hdl/hierarchical_pivot_transform.sv
// Top level: places a child node in world space from its parent's transform.
//
// Input channel: drive the req_ fields and raise start; an item is taken at
// each rising edge with start high and busy low. busy is high only while
// reset is held, so one item can be taken every cycle.
// Result channel: rsp_valid strobes for one cycle with the rsp_ fields; there
// is no back-pressure, the receiver must take the item in that cycle.
// Throughput is one item per cycle. The pipeline holds the CORDIC: one
// register stage per micro-rotation, plus angle reduction, rounding, the
// rotation multipliers, and the two saturating position adds (anchor,
// then centre from the saturated anchor).
// Configuration: csr_data with csr_valid writes the zoom (Q8.8); csr_ready is
// always high. Write it only while no item is in flight.
// Reset: synchronous; clears every valid bit and sets the zoom to 1.0. Items
// in flight are dropped. No clearing pass is needed.
module hierarchical_pivot_transform #(
   parameter int TRIG_BITS = hpt_pkg::TRIG_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [hpt_pkg::POS_W-1:0]    req_parent_x,
   input  logic signed [hpt_pkg::POS_W-1:0]    req_parent_y,
   input  logic signed [hpt_pkg::ANGLE_W-1:0]  req_parent_angle,
   input  logic signed [hpt_pkg::ANGLE_W-1:0]  req_node_angle,
   input  logic signed [hpt_pkg::FRAC_W-1:0]   req_pivot_x,
   input  logic signed [hpt_pkg::FRAC_W-1:0]   req_pivot_y,
   input  logic        [hpt_pkg::SIZE_W-1:0]   req_parent_width,
   input  logic        [hpt_pkg::SIZE_W-1:0]   req_parent_height,
   input  logic        [hpt_pkg::SIZE_W-1:0]   req_own_width,
   input  logic        [hpt_pkg::SIZE_W-1:0]   req_own_height,
   input  logic signed [hpt_pkg::FRAC_W-1:0]   req_offset_x,
   input  logic signed [hpt_pkg::FRAC_W-1:0]   req_offset_y,
   output logic                                rsp_valid,
   output logic signed [hpt_pkg::POS_W-1:0]    rsp_center_x,
   output logic signed [hpt_pkg::POS_W-1:0]    rsp_center_y,
   output logic signed [hpt_pkg::ANGLE_W-1:0]  rsp_world_angle,
   output logic signed [hpt_pkg::POS_W-1:0]    rsp_anchor_x,
   output logic signed [hpt_pkg::POS_W-1:0]    rsp_anchor_y,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic        [hpt_pkg::ZOOM_W-1:0]   csr_data
);
   import hpt_pkg::*;

   localparam int N_ITER  = (TRIG_BITS > TRIG_MAX) ? TRIG_MAX : TRIG_BITS;
   localparam int SC_LAT  = N_ITER + 3;   // sine/cosine latency
   localparam int ROT_LAT = 2;

   logic accept;
   assign busy      = reset;
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   // Zoom register
   logic [ZOOM_W-1:0] zoom_ff, zoom_in;
   always_comb begin
      zoom_in = zoom_ff;
      if (csr_valid && csr_ready)
         zoom_in = csr_data;
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         zoom_ff <= ZOOM_RESET;
      end else begin
         zoom_ff <= zoom_in;
      end
   end

   // Stage 1: capture, saturate the angle sum, fraction times size
   logic v1_ff;
   scal_type s1_ff, s1_in;
   logic signed [ANGLE_W-1:0] pa1_ff;
   logic signed [FS_W-1:0] fpx_ff, fpy_ff, fox_ff, foy_ff;
   logic signed [FS_W-1:0] fpx_in, fpy_in, fox_in, foy_in;
   logic signed [ANGLE_W:0] asum;

   always_comb begin
      asum = (ANGLE_W+1)'(req_parent_angle) + (ANGLE_W+1)'(req_node_angle);
      s1_in.px = req_parent_x;
      s1_in.py = req_parent_y;
      if (asum > (ANGLE_W+1)'(2**(ANGLE_W-1) - 1))
         s1_in.wa = {1'b0, {(ANGLE_W-1){1'b1}}};
      else if (asum < -(ANGLE_W+1)'(2**(ANGLE_W-1)))
         s1_in.wa = {1'b1, {(ANGLE_W-1){1'b0}}};
      else
         s1_in.wa = asum[ANGLE_W-1:0];
      fpx_in = req_pivot_x  * $signed({1'b0, req_parent_width});
      fpy_in = req_pivot_y  * $signed({1'b0, req_parent_height});
      fox_in = req_offset_x * $signed({1'b0, req_own_width});
      foy_in = req_offset_y * $signed({1'b0, req_own_height});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
      end
   end
   always_ff @(posedge clock) begin
      s1_ff  <= s1_in;
      pa1_ff <= req_parent_angle;
      fpx_ff <= fpx_in;
      fpy_ff <= fpy_in;
      fox_ff <= fox_in;
      foy_ff <= foy_in;
   end

   // Sine and cosine of the parent and world angles
   logic signed [TRIG_W-1:0] sin_p, cos_p, sin_w, cos_w;

   hpt_sincos #(.TRIG_BITS(TRIG_BITS)) u_sc_parent (
      .clock   (clock),
      .angle   (pa1_ff),
      .sin_q14 (sin_p),
      .cos_q14 (cos_p)
   );

   hpt_sincos #(.TRIG_BITS(TRIG_BITS)) u_sc_world (
      .clock   (clock),
      .angle   (s1_ff.wa),
      .sin_q14 (sin_w),
      .cos_q14 (cos_w)
   );

   // Stage 2: scale by zoom to Q.22
   logic v2_ff;
   stage_type st2_ff, st2_in;
   logic signed [ZOOM_W:0] zs;

   always_comb begin
      zs = $signed({1'b0, zoom_ff});
      st2_in.scal    = s1_ff;
      st2_in.vec.pvx = fpx_ff * zs;
      st2_in.vec.pvy = fpy_ff * zs;
      st2_in.vec.ofx = fox_ff * zs;
      st2_in.vec.ofy = foy_ff * zs;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
   end
   always_ff @(posedge clock) begin
      st2_ff <= st2_in;
   end

   // Hold vectors and scalars until sine and cosine arrive
   logic v3;
   stage_type st3;

   hpt_delay #(.DEPTH(SC_LAT - 1), .WIDTH($bits(stage_type))) u_align (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v2_ff),
      .in_data   (st2_ff),
      .out_valid (v3),
      .out_data  (st3)
   );

   // Rotate the pivot by the parent angle, the offset by the world angle
   logic signed [RES_W-1:0] rpx, rpy, rox, roy;

   hpt_rotate u_rot_pivot (
      .clock   (clock),
      .vx      (st3.vec.pvx),
      .vy      (st3.vec.pvy),
      .sin_q14 (sin_p),
      .cos_q14 (cos_p),
      .rx      (rpx),
      .ry      (rpy)
   );

   hpt_rotate u_rot_offset (
      .clock   (clock),
      .vx      (st3.vec.ofx),
      .vy      (st3.vec.ofy),
      .sin_q14 (sin_w),
      .cos_q14 (cos_w),
      .rx      (rox),
      .ry      (roy)
   );

   logic v4;
   scal_type s4;

   hpt_delay #(.DEPTH(ROT_LAT), .WIDTH($bits(scal_type))) u_rot_align (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v3),
      .in_data   (st3.scal),
      .out_valid (v4),
      .out_data  (s4)
   );

   // Anchor stage: saturate parent position plus rotated pivot
   logic v5_ff;
   logic signed [POS_W-1:0]   ax_ff, ay_ff, ax_in, ay_in;
   logic signed [ANGLE_W-1:0] wa5_ff;
   logic signed [RES_W-1:0]   rox_ff, roy_ff;

   always_comb begin
      ax_in = hpt_sat_add(s4.px, rpx);
      ay_in = hpt_sat_add(s4.py, rpy);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= v4;
      end
   end
   always_ff @(posedge clock) begin
      ax_ff  <= ax_in;
      ay_ff  <= ay_in;
      wa5_ff <= s4.wa;
      rox_ff <= rox;
      roy_ff <= roy;
   end

   // Centre stage: add the rotated offset to the saturated anchor
   logic v6_ff;
   logic signed [POS_W-1:0]   cx_ff, cy_ff, cx_in, cy_in;
   logic signed [POS_W-1:0]   ax6_ff, ay6_ff;
   logic signed [ANGLE_W-1:0] wa6_ff;

   always_comb begin
      cx_in = hpt_sat_add(ax_ff, rox_ff);
      cy_in = hpt_sat_add(ay_ff, roy_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else begin
         v6_ff <= v5_ff;
      end
   end
   always_ff @(posedge clock) begin
      cx_ff  <= cx_in;
      cy_ff  <= cy_in;
      ax6_ff <= ax_ff;
      ay6_ff <= ay_ff;
      wa6_ff <= wa5_ff;
   end

   assign rsp_valid       = v6_ff;
   assign rsp_center_x    = cx_ff;
   assign rsp_center_y    = cy_ff;
   assign rsp_world_angle = wa6_ff;
   assign rsp_anchor_x    = ax6_ff;
   assign rsp_anchor_y    = ay6_ff;
endmodule

>>> hdl/hpt_checker.sv
// Port-level checker for the pivot transform, bound to the top level.
`include "hierarchical_pivot_transform_macros.svh"

module hpt_checker #(
   parameter int TRIG_BITS = hpt_pkg::TRIG_BITS_DEFAULT
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               start,
   input logic                               busy,
   input logic signed [hpt_pkg::POS_W-1:0]   req_parent_x,
   input logic signed [hpt_pkg::ANGLE_W-1:0] req_parent_angle,
   input logic signed [hpt_pkg::ANGLE_W-1:0] req_node_angle,
   input logic        [hpt_pkg::SIZE_W-1:0]  req_parent_width,
   input logic        [hpt_pkg::SIZE_W-1:0]  req_parent_height,
   input logic                               rsp_valid,
   input logic signed [hpt_pkg::ANGLE_W-1:0] rsp_world_angle,
   input logic signed [hpt_pkg::POS_W-1:0]   rsp_anchor_x
);
   import hpt_pkg::*;

   localparam int LAT = ((TRIG_BITS > TRIG_MAX) ? TRIG_MAX : TRIG_BITS) + 8;

   logic signed [ANGLE_W:0]   asum;
   logic signed [ANGLE_W-1:0] wa_exp;
   logic                      no_parent;

   always_comb begin
      asum = (ANGLE_W+1)'(req_parent_angle) + (ANGLE_W+1)'(req_node_angle);
      if (asum > (ANGLE_W+1)'(2**(ANGLE_W-1) - 1))
         wa_exp = {1'b0, {(ANGLE_W-1){1'b1}}};
      else if (asum < -(ANGLE_W+1)'(2**(ANGLE_W-1)))
         wa_exp = {1'b1, {(ANGLE_W-1){1'b0}}};
      else
         wa_exp = asum[ANGLE_W-1:0];
      no_parent = (req_parent_width == '0) && (req_parent_height == '0);
   end

   `HPT_ASSERT_NEXT(a_reset_clears, clock, reset, !rsp_valid)
   `HPT_ASSERT_IMPLY(a_result_has_item, clock, reset, rsp_valid, $past(start && !busy, LAT))
   `HPT_ASSERT_IMPLY(a_world_angle, clock, reset, rsp_valid, rsp_world_angle == $past(wa_exp, LAT))
   `HPT_ASSERT_IMPLY(a_no_parent_anchor, clock, reset, rsp_valid && $past(no_parent, LAT), rsp_anchor_x == $past(req_parent_x, LAT))
endmodule

bind hierarchical_pivot_transform hpt_checker #(.TRIG_BITS(TRIG_BITS)) u_hpt_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .req_parent_x      (req_parent_x),
   .req_parent_angle  (req_parent_angle),
   .req_node_angle    (req_node_angle),
   .req_parent_width  (req_parent_width),
   .req_parent_height (req_parent_height),
   .rsp_valid         (rsp_valid),
   .rsp_world_angle   (rsp_world_angle),
   .rsp_anchor_x      (rsp_anchor_x)
);

>>> sim/hpt_placement_checker.sv
// Checker for the pivot transform: predicts each placement and compares results.
module hpt_placement_checker #(
   parameter int TRIG_BITS = hpt_pkg::TRIG_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                busy,
   input  logic signed [hpt_pkg::POS_W-1:0]    req_parent_x,
   input  logic signed [hpt_pkg::POS_W-1:0]    req_parent_y,
   input  logic signed [hpt_pkg::ANGLE_W-1:0]  req_parent_angle,
   input  logic signed [hpt_pkg::ANGLE_W-1:0]  req_node_angle,
   input  logic signed [hpt_pkg::FRAC_W-1:0]   req_pivot_x,
   input  logic signed [hpt_pkg::FRAC_W-1:0]   req_pivot_y,
   input  logic        [hpt_pkg::SIZE_W-1:0]   req_parent_width,
   input  logic        [hpt_pkg::SIZE_W-1:0]   req_parent_height,
   input  logic        [hpt_pkg::SIZE_W-1:0]   req_own_width,
   input  logic        [hpt_pkg::SIZE_W-1:0]   req_own_height,
   input  logic signed [hpt_pkg::FRAC_W-1:0]   req_offset_x,
   input  logic signed [hpt_pkg::FRAC_W-1:0]   req_offset_y,
   input  logic                                rsp_valid,
   input  logic signed [hpt_pkg::POS_W-1:0]    rsp_center_x,
   input  logic signed [hpt_pkg::POS_W-1:0]    rsp_center_y,
   input  logic signed [hpt_pkg::ANGLE_W-1:0]  rsp_world_angle,
   input  logic signed [hpt_pkg::POS_W-1:0]    rsp_anchor_x,
   input  logic signed [hpt_pkg::POS_W-1:0]    rsp_anchor_y,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic        [hpt_pkg::ZOOM_W-1:0]   csr_data,
   output int                                  fail_count,
   output int                                  placements_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import hpt_pkg::*;

   typedef struct {
      logic signed [POS_W-1:0]   center_x;
      logic signed [POS_W-1:0]   center_y;
      logic signed [ANGLE_W-1:0] world_angle;
      logic signed [POS_W-1:0]   anchor_x;
      logic signed [POS_W-1:0]   anchor_y;
   } placement_t;

   localparam longint POS_MAX   = 64'sd2147483647;
   localparam longint POS_MIN   = -64'sd2147483648;
   localparam longint ANGLE_MAX = 64'sd8388607;
   localparam longint ANGLE_MIN = -64'sd8388608;
   localparam longint DEG_90    = 64'sd90 * 65536;

   const longint atan_steps[24] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0};

   logic [ZOOM_W-1:0] zoom;
   placement_t        expected_placements[$];

   assign placements_pending = expected_placements.size();

   function automatic longint clamp(input longint v, input longint lo, input longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // Q16.8 degrees in, Q1.14 sine and cosine out.
   function automatic void cordic_sincos(input longint angle, output longint s,
                                         output longint c);
      longint r, d, x, y, nx;
      bit     flip;
      int     n;
      n = TRIG_BITS > 24 ? 24 : TRIG_BITS;
      flip = 0;
      r = angle % 92160;
      if (r < 0) r += 92160;
      d = r * 256;
      if (d > 2 * DEG_90) d -= 4 * DEG_90;
      if (d > DEG_90) begin
         d -= 2 * DEG_90;
         flip = 1;
      end else if (d < -DEG_90) begin
         d += 2 * DEG_90;
         flip = 1;
      end
      x = 64'sd652032874;
      y = 0;
      for (int i = 0; i < n; i++) begin
         if (d >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            d -= atan_steps[i];
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            d += atan_steps[i];
         end
         x = nx;
      end
      x = (x + 32768) >>> 16;
      y = (y + 32768) >>> 16;
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   // Rotate a Q.22 vector, result rounded half up to Q.8.
   function automatic void rotate_vec(input longint vx, input longint vy, input longint angle,
                                      output longint rx, output longint ry);
      longint s, c;
      cordic_sincos(angle, s, c);
      rx = (vx * c - vy * s + (64'sd1 <<< 27)) >>> 28;
      ry = (vx * s + vy * c + (64'sd1 <<< 27)) >>> 28;
   endfunction

   function automatic placement_t place_child();
      placement_t p;
      longint z, wa, rx, ry, ax, ay;
      z  = longint'(zoom);
      wa = clamp(longint'(req_parent_angle) + longint'(req_node_angle), ANGLE_MIN, ANGLE_MAX);
      rotate_vec(longint'(req_pivot_x) * longint'(req_parent_width) * z,
                 longint'(req_pivot_y) * longint'(req_parent_height) * z,
                 longint'(req_parent_angle), rx, ry);
      ax = clamp(longint'(req_parent_x) + rx, POS_MIN, POS_MAX);
      ay = clamp(longint'(req_parent_y) + ry, POS_MIN, POS_MAX);
      rotate_vec(longint'(req_offset_x) * longint'(req_own_width) * z,
                 longint'(req_offset_y) * longint'(req_own_height) * z, wa, rx, ry);
      p.center_x    = POS_W'(clamp(ax + rx, POS_MIN, POS_MAX));
      p.center_y    = POS_W'(clamp(ay + ry, POS_MIN, POS_MAX));
      p.world_angle = ANGLE_W'(wa);
      p.anchor_x    = POS_W'(ax);
      p.anchor_y    = POS_W'(ay);
      return p;
   endfunction

   task automatic check_field(input string name, input longint exp_v, input longint act_v);
      if (exp_v != act_v) begin
         $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      placement_t e;
      if (reset) begin
         zoom = ZOOM_RESET;
         expected_placements.delete();
      end else begin
         // Results first: an item accepted now cannot come out in the same cycle.
         if (rsp_valid) begin
            if (expected_placements.size() == 0) begin
               $error("unexpected result item");
               fail_count++;
            end else begin
               e = expected_placements.pop_front();
               check_field("center_x", e.center_x, rsp_center_x);
               check_field("center_y", e.center_y, rsp_center_y);
               check_field("world_angle", e.world_angle, rsp_world_angle);
               check_field("anchor_x", e.anchor_x, rsp_anchor_x);
               check_field("anchor_y", e.anchor_y, rsp_anchor_y);
            end
         end
         if (start && !busy) expected_placements.push_back(place_child());
         if (csr_valid && csr_ready) zoom = csr_data;
      end
   end

endmodule

>>> sim/tb.sv
// Testbench top: drives items and zoom settings into the pivot transform, gives the verdict.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import hpt_pkg::*;

   localparam int LATENCY     = TRIG_BITS_DEFAULT + 8;
   localparam int SETTLE      = 4 * LATENCY;
   localparam int IDLE_LIMIT  = 2000;
   localparam int RANDOM_ITEMS = 800;

   typedef struct {
      logic signed [POS_W-1:0]   parent_x, parent_y;
      logic signed [ANGLE_W-1:0] parent_angle, node_angle;
      logic signed [FRAC_W-1:0]  pivot_x, pivot_y, offset_x, offset_y;
      logic        [SIZE_W-1:0]  parent_width, parent_height, own_width, own_height;
   } node_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [POS_W-1:0]   req_parent_x = '0, req_parent_y = '0;
   logic signed [ANGLE_W-1:0] req_parent_angle = '0, req_node_angle = '0;
   logic signed [FRAC_W-1:0]  req_pivot_x = '0, req_pivot_y = '0;
   logic        [SIZE_W-1:0]  req_parent_width = '0, req_parent_height = '0;
   logic        [SIZE_W-1:0]  req_own_width = '0, req_own_height = '0;
   logic signed [FRAC_W-1:0]  req_offset_x = '0, req_offset_y = '0;
   logic                      rsp_valid;
   logic signed [POS_W-1:0]   rsp_center_x, rsp_center_y, rsp_anchor_x, rsp_anchor_y;
   logic signed [ANGLE_W-1:0] rsp_world_angle;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [ZOOM_W-1:0]         csr_data = '0;
   int                        fail_count, placements_pending;
   int                        idle_cycles = 0;
   bit                        no_gaps = 0;   // when set, items go back to back

   initial forever #5 clock = ~clock;

   hierarchical_pivot_transform DUT (.*);
   hpt_placement_checker checker_i (.*);

   // Watchdog: count cycles in which no handshake of any kind completes.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   // Present one item; hold start high into the next item when there is no gap.
   task automatic send_item(input node_item_type it);
      int gap;
      gap = no_gaps ? 0 : int'($urandom_range(0, 12));
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_parent_x      <= it.parent_x;
      req_parent_y      <= it.parent_y;
      req_parent_angle  <= it.parent_angle;
      req_node_angle    <= it.node_angle;
      req_pivot_x       <= it.pivot_x;
      req_pivot_y       <= it.pivot_y;
      req_parent_width  <= it.parent_width;
      req_parent_height <= it.parent_height;
      req_own_width     <= it.own_width;
      req_own_height    <= it.own_height;
      req_offset_x      <= it.offset_x;
      req_offset_y      <= it.offset_y;
      start             <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   // Drain the pipeline, then write the zoom while nothing is in flight.
   task automatic write_zoom(input logic [ZOOM_W-1:0] z);
      start <= 1'b0;
      @(posedge clock);
      while (placements_pending != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= z;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic node_item_type blank_item();
      node_item_type it;
      it = '{default: '0};
      return it;
   endfunction

   // Mostly modest sizes and positions, with occasional extremes to hit the clamps.
   function automatic node_item_type random_item();
      node_item_type it;
      int mode;
      mode = int'($urandom_range(0, 9));
      it.parent_x      = (mode == 0) ? POS_W'($urandom)
                                     : POS_W'($signed($urandom_range(0, 2000000)) - 1000000);
      it.parent_y      = (mode == 1) ? POS_W'($urandom)
                                     : POS_W'($signed($urandom_range(0, 2000000)) - 1000000);
      it.parent_angle  = ANGLE_W'($urandom);
      it.node_angle    = (mode == 2) ? (it.parent_angle[ANGLE_W-1] ? 24'h800000 : 24'h7FFFFF)
                                     : ANGLE_W'($urandom);
      if (mode == 3) begin
         it.parent_angle = ANGLE_W'($signed($urandom_range(0, 184320)) - 92160);
         it.node_angle   = ANGLE_W'($signed($urandom_range(0, 184320)) - 92160);
      end
      it.pivot_x       = FRAC_W'($urandom);
      it.pivot_y       = FRAC_W'($urandom);
      it.offset_x      = FRAC_W'($urandom);
      it.offset_y      = FRAC_W'($urandom);
      it.parent_width  = (mode >= 8) ? SIZE_W'($urandom) : SIZE_W'($urandom_range(0, 400));
      it.parent_height = (mode >= 8) ? SIZE_W'($urandom) : SIZE_W'($urandom_range(0, 400));
      it.own_width     = (mode >= 7) ? SIZE_W'($urandom) : SIZE_W'($urandom_range(0, 400));
      it.own_height    = (mode >= 7) ? SIZE_W'($urandom) : SIZE_W'($urandom_range(0, 400));
      // Drop a frame now and then.
      if ($urandom_range(0, 9) == 0) begin
         it.parent_width = '0;
         it.parent_height = '0;
      end
      if ($urandom_range(0, 9) == 0) begin
         it.own_width = '0;
         it.own_height = '0;
      end
      return it;
   endfunction

   task automatic run_directed();
      node_item_type it;
      // All zero: everything collapses onto the origin.
      send_item(blank_item());
      // Largest frames and pivots, both angle extremes: angle clamps high and low.
      it = blank_item();
      it.parent_x = 32'h7FFFFFFF; it.parent_y = 32'h80000000;
      it.parent_angle = 24'h7FFFFF; it.node_angle = 24'h7FFFFF;
      it.pivot_x = 16'h7FFF; it.pivot_y = 16'h8000;
      it.offset_x = 16'h8000; it.offset_y = 16'h7FFF;
      it.parent_width = 16'hFFFF; it.parent_height = 16'hFFFF;
      it.own_width = 16'hFFFF; it.own_height = 16'hFFFF;
      send_item(it);
      it.parent_angle = 24'h800000; it.node_angle = 24'h800000;
      it.parent_x = 32'h80000000; it.parent_y = 32'h7FFFFFFF;
      send_item(it);
      // Missing parent frame: anchor sits on the parent position.
      it.parent_width = '0; it.parent_height = '0;
      it.parent_x = 32'sd12345; it.parent_angle = 24'sd11520;
      send_item(it);
      // Missing child frame: centre equals the anchor.
      it.parent_width = 16'd300; it.parent_height = 16'd200;
      it.own_width = '0; it.own_height = '0;
      send_item(it);
      // Quadrant boundaries of the angle reduction.
      for (int q = -4; q <= 4; q++) begin
         it = blank_item();
         it.parent_angle = ANGLE_W'(q * 23040);
         it.node_angle = ANGLE_W'(q * 11520);
         it.pivot_x = 16'sd8192; it.pivot_y = -16'sd4096;
         it.offset_x = 16'sd16384; it.offset_y = 16'sd16384;
         it.parent_width = 16'd640; it.parent_height = 16'd480;
         it.own_width = 16'd64; it.own_height = 16'd32;
         send_item(it);
      end
      // Sum just past each end of the angle range.
      it.parent_angle = 24'sd8388000; it.node_angle = 24'sd1000;
      send_item(it);
      it.parent_angle = -24'sd8388000; it.node_angle = -24'sd1000;
      send_item(it);
   endtask

   initial begin
      logic [ZOOM_W-1:0] zooms[6];
      zooms = '{16'd256, 16'hFFFF, 16'd1, 16'd0, 16'd512, 16'd0};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed items under the reset zoom, then under the extremes.
      run_directed();
      write_zoom(16'hFFFF);
      run_directed();
      write_zoom(16'd0);
      run_directed();

      // Random phases, each under its own zoom; some phases run back to back.
      for (int ph = 0; ph < 8; ph++) begin
         zooms[5] = ZOOM_W'($urandom_range(1, 65535));
         write_zoom(zooms[ph % 6]);
         no_gaps = ($urandom_range(0, 2) == 0);
         for (int n = 0; n < RANDOM_ITEMS / 8; n++) begin
            if (!no_gaps && $urandom_range(0, 19) == 0) no_gaps = 1;
            else if (no_gaps && $urandom_range(0, 29) == 0) no_gaps = 0;
            send_item(random_item());
         end
      end
      start <= 1'b0;

      // Drain, then allow for the pipeline latency.
      while (placements_pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
